[rtl/mrs_pkg.sv]
// Shared types, constants and the CRC step function of the Modbus RTU slave frame engine.
package mrs_pkg;

    localparam int TABLE_DEPTH_DEF = 128;
    localparam int FRAME_BYTES_DEF = 64;
    localparam int MAX_REPLY_DEF   = 64;

    localparam logic [7:0]  DEVICE_ID_RST   = 8'd50;
    localparam logic [7:0]  TABLE_LIMIT_RST = 8'd100;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_LIMIT = 2'd1;

    localparam logic [7:0] FC_RD_COILS  = 8'h01;
    localparam logic [7:0] FC_RD_INPUTS = 8'h02;
    localparam logic [7:0] FC_RD_HOLD   = 8'h03;
    localparam logic [7:0] FC_RD_INREG  = 8'h04;
    localparam logic [7:0] FC_WR_COIL   = 8'h05;
    localparam logic [7:0] FC_WR_REG    = 8'h06;
    localparam logic [7:0] FC_WR_COILS  = 8'h0F;
    localparam logic [7:0] FC_WR_REGS   = 8'h10;

    typedef enum logic [2:0] {
        LD_NONE, LD_HDR, LD_COIL, LD_RHI, LD_RLO, LD_CLO, LD_CHI
    } load_t;

    typedef enum logic [2:0] {
        K_NONE, K_RCOIL, K_RREG, K_WONE, K_WCOILS, K_WREGS
    } kind_t;

    typedef struct packed {
        logic  frame_clr;
        logic  idx_clr;
        logic  idx_inc;
        logic  sub_clr;
        logic  sub_inc;
        logic  buf_issue;
        logic  hi_take;
        logic  tbl_put;
        logic  gather;
        logic  reg_issue;
        load_t load;
    } mrs_cmd_t;

    typedef struct packed {
        logic  accept;
        kind_t kind;
        logic  idx_last;
        logic  cnt_zero;
        logic  hdr_last;
        logic  sub_eight;
    } mrs_sts_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

[rtl/mrs_rx_if.sv]
// Receive channel: frame bytes with end-of-frame mark.
interface mrs_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;
    modport source (output valid, rx_byte, frame_end, input ready);
    modport sink   (input valid, rx_byte, frame_end, output ready);
endinterface

[rtl/mrs_tx_if.sv]
// Transmit channel: reply bytes with last-byte mark.
interface mrs_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       tx_last;
    modport source (output valid, tx_byte, tx_last, input ready);
    modport sink   (input valid, tx_byte, tx_last, output ready);
endinterface

[rtl/mrs_datapath.sv]
// Datapath: frame buffer, header decode, checks, coil and register tables, reply bytes.
module mrs_datapath
    import mrs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int MAX_REPLY   = MAX_REPLY_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_fire,
    input  logic [7:0] rx_byte,
    input  logic [7:0] device_id,
    input  logic [7:0] table_limit,
    input  mrs_cmd_t   cmd,
    output mrs_sts_t   sts,
    output logic [7:0] tx_byte,
    output logic       tx_last
);

    localparam int AW  = $clog2(FRAME_BYTES);
    localparam int NW  = $clog2(FRAME_BYTES + 1);
    localparam int TW  = $clog2(TABLE_DEPTH);
    localparam int LW  = $clog2(TABLE_DEPTH + 1);
    localparam int LMW = (LW > 8) ? LW : 8;

    logic [7:0]       buf_mem [FRAME_BYTES];
    logic [7:0]       buf_q_reg;
    logic [NW-1:0]    count_reg;
    logic             ovf_reg;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       hdr_reg [7];
    logic [15:0]      idx_reg;
    logic [3:0]       sub_reg;
    logic [7:0]       hi_reg;
    logic [7:0]       gath_reg;
    logic [7:0]       tx_byte_reg;
    logic             tx_last_reg;

    logic             coil_mem [TABLE_DEPTH];
    logic [15:0]      reg_mem  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] coil_vld_reg;
    logic [TABLE_DEPTH-1:0] reg_vld_reg;
    logic             coil_q_reg, coil_ok_reg;
    logic [15:0]      reg_q_reg;
    logic             reg_ok_reg;

    logic [7:0]       fc, bc;
    logic [15:0]      addr, qty, cnt;
    logic [16:0]      qty2;
    logic [13:0]      nb;
    kind_t            kind;
    logic [9:0]       n10, bc9;
    logic             len_ok, fit_ok, is_write, put_coil, in_rng;
    logic [LMW-1:0]   tl_ext, lim;
    logic [19:0]      a_sel;
    logic [18:0]      elem;
    logic [TW-1:0]    tidx;
    logic [17:0]      buf_ra;
    logic             coil_wv;
    logic [15:0]      reg_wv, rval;
    logic [7:0]       hbyte, ld_byte;

    assign fc   = hdr_reg[1];
    assign bc   = hdr_reg[6];
    assign addr = {hdr_reg[2], hdr_reg[3]};
    assign qty  = {hdr_reg[4], hdr_reg[5]};
    assign qty2 = {qty, 1'b0};
    assign nb   = 14'((17'(qty) + 17'd7) >> 3);
    assign n10  = 10'(count_reg);
    assign bc9  = 10'(bc) + 10'd9;

    always_comb
    begin
        unique case (fc) inside
            FC_RD_COILS, FC_RD_INPUTS: kind = K_RCOIL;
            FC_RD_HOLD, FC_RD_INREG:   kind = K_RREG;
            FC_WR_COIL, FC_WR_REG:     kind = K_WONE;
            FC_WR_COILS:               kind = K_WCOILS;
            FC_WR_REGS:                kind = K_WREGS;
            default:                   kind = K_NONE;
        endcase
    end

    always_comb
    begin
        len_ok = 1'b0;
        fit_ok = 1'b1;
        cnt    = qty;
        case (kind)
            K_RCOIL:
            begin
                len_ok = (n10 == 10'd8);
                fit_ok = (15'(nb) + 15'd5) <= 15'(MAX_REPLY);
                cnt    = 16'(nb);
            end
            K_RREG:
            begin
                len_ok = (n10 == 10'd8);
                fit_ok = (18'(qty2) + 18'd5) <= 18'(MAX_REPLY);
            end
            K_WONE:   len_ok = (n10 == 10'd8);
            K_WCOILS: len_ok = (n10 == bc9) && (nb <= 14'(bc));
            K_WREGS:  len_ok = (n10 == bc9) && (qty2 <= 17'(bc));
            default:  len_ok = 1'b0;
        endcase
    end

    assign is_write = (kind == K_WONE) || (kind == K_WCOILS) || (kind == K_WREGS);
    assign put_coil = (kind == K_WCOILS) || ((kind == K_WONE) && (fc == FC_WR_COIL));

    assign sts.accept    = !ovf_reg && (n10 >= 10'd4) && (hdr_reg[0] == device_id)
                           && (crc_reg == 16'h0000) && (kind != K_NONE) && len_ok && fit_ok;
    assign sts.kind      = kind;
    assign sts.idx_last  = (idx_reg == cnt - 16'd1);
    assign sts.cnt_zero  = (cnt == 16'd0);
    assign sts.hdr_last  = is_write ? (idx_reg == 16'd5) : (idx_reg == 16'd2);
    assign sts.sub_eight = (sub_reg == 4'd8);

    assign tl_ext = LMW'(table_limit);
    assign lim    = (tl_ext >= LMW'(TABLE_DEPTH)) ? LMW'(TABLE_DEPTH) : tl_ext;
    assign elem   = 19'({idx_reg, 3'b000}) + 19'(sub_reg);
    assign a_sel  = (kind == K_RCOIL) ? (20'(addr) + 20'(elem)) : (20'(addr) + 20'(idx_reg));
    assign in_rng = a_sel < 20'(lim);
    assign tidx   = a_sel[TW-1:0];
    assign buf_ra = (kind == K_WCOILS) ? (18'(idx_reg[15:3]) + 18'd7)
                                       : (18'({idx_reg, 1'b0}) + 18'(sub_reg) + 18'd7);

    assign coil_wv = (kind == K_WCOILS) ? buf_q_reg[idx_reg[2:0]] : (qty != 16'd0);
    assign reg_wv  = (kind == K_WREGS) ? {hi_reg, buf_q_reg} : qty;
    assign rval    = reg_ok_reg ? reg_q_reg : 16'h0000;

    always_comb
    begin
        if (is_write || idx_reg < 16'd2)
            hbyte = hdr_reg[idx_reg[2:0]];
        else if (kind == K_RCOIL)
            hbyte = nb[7:0];
        else
            hbyte = qty2[7:0];
    end

    always_comb
    begin
        case (cmd.load)
            LD_HDR:  ld_byte = hbyte;
            LD_COIL: ld_byte = gath_reg;
            LD_RHI:  ld_byte = rval[15:8];
            LD_RLO:  ld_byte = rval[7:0];
            LD_CLO:  ld_byte = crc_reg[7:0];
            LD_CHI:  ld_byte = crc_reg[15:8];
            default: ld_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        crc_next = crc_reg;
        if (cmd.frame_clr)
            crc_next = CRC_INIT;
        else if (rx_fire && n10 < 10'(FRAME_BYTES))
            crc_next = crc_byte(crc_reg, rx_byte);
        else if (cmd.load != LD_NONE && cmd.load != LD_CLO && cmd.load != LD_CHI)
            crc_next = crc_byte(crc_reg, ld_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            crc_reg      <= CRC_INIT;
            idx_reg      <= '0;
            sub_reg      <= '0;
            coil_vld_reg <= '0;
            reg_vld_reg  <= '0;
        end
        else
        begin
            crc_reg <= crc_next;
            if (cmd.frame_clr)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (rx_fire)
            begin
                if (n10 < 10'(FRAME_BYTES))
                    count_reg <= count_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 16'd1;
            if (cmd.sub_clr)
                sub_reg <= '0;
            else if (cmd.sub_inc)
                sub_reg <= sub_reg + 4'd1;
            if (cmd.tbl_put && in_rng && put_coil)
                coil_vld_reg[tidx] <= 1'b1;
            if (cmd.tbl_put && in_rng && !put_coil)
                reg_vld_reg[tidx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire && n10 < 10'(FRAME_BYTES))
        begin
            buf_mem[count_reg[AW-1:0]] <= rx_byte;
            if (n10 < 10'd7)
                hdr_reg[count_reg[2:0]] <= rx_byte;
        end
        if (cmd.buf_issue)
            buf_q_reg <= buf_mem[buf_ra[AW-1:0]];
        if (cmd.hi_take)
            hi_reg <= buf_q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tbl_put && in_rng && put_coil)
            coil_mem[tidx] <= coil_wv;
        if (cmd.tbl_put && in_rng && !put_coil)
            reg_mem[tidx] <= reg_wv;
        if (cmd.gather && sub_reg < 4'd8)
        begin
            coil_q_reg  <= coil_mem[tidx];
            coil_ok_reg <= coil_vld_reg[tidx] && in_rng && (elem < 19'(qty));
        end
        if (cmd.gather && sub_reg != 4'd0)
            gath_reg <= {coil_q_reg & coil_ok_reg, gath_reg[7:1]};
        if (cmd.reg_issue)
        begin
            reg_q_reg  <= reg_mem[tidx];
            reg_ok_reg <= reg_vld_reg[tidx] && in_rng;
        end
        if (cmd.load != LD_NONE)
        begin
            tx_byte_reg <= ld_byte;
            tx_last_reg <= (cmd.load == LD_CHI);
        end
    end

    assign tx_byte = tx_byte_reg;
    assign tx_last = tx_last_reg;

endmodule

[rtl/mrs_ctrl.sv]
// Controller: receive, check, table update and reply sequencing.
module mrs_ctrl
    import mrs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     frame_end,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  mrs_sts_t sts,
    output mrs_cmd_t cmd
);

    typedef enum logic [14:0] {
        S_RECV  = 15'b000000000000001,
        S_CHECK = 15'b000000000000010,
        S_PUT   = 15'b000000000000100,
        S_WISS  = 15'b000000000001000,
        S_WHI   = 15'b000000000010000,
        S_WPUT  = 15'b000000000100000,
        S_HDR   = 15'b000000001000000,
        S_GATH  = 15'b000000010000000,
        S_CBYTE = 15'b000000100000000,
        S_RRD   = 15'b000001000000000,
        S_RHI   = 15'b000010000000000,
        S_RLO   = 15'b000100000000000,
        S_CLO   = 15'b001000000000000,
        S_CHI   = 15'b010000000000000,
        S_OUT   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;

    assign in_ready  = (state_reg == S_RECV);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        unique case (state_reg)
            S_RECV:
            begin
                if (in_valid && frame_end)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.frame_clr = 1'b1;
                cmd.idx_clr   = 1'b1;
                cmd.sub_clr   = 1'b1;
                if (!sts.accept)
                    state_next = S_RECV;
                else if (sts.kind == K_WONE)
                    state_next = S_PUT;
                else if ((sts.kind == K_WCOILS || sts.kind == K_WREGS) && !sts.cnt_zero)
                    state_next = S_WISS;
                else
                    state_next = S_HDR;
            end
            S_PUT:
            begin
                cmd.tbl_put = 1'b1;
                state_next  = S_HDR;
            end
            S_WISS:
            begin
                cmd.buf_issue = 1'b1;
                if (sts.kind == K_WREGS)
                begin
                    cmd.sub_inc = 1'b1;
                    state_next  = S_WHI;
                end
                else
                    state_next = S_WPUT;
            end
            S_WHI:
            begin
                cmd.hi_take   = 1'b1;
                cmd.buf_issue = 1'b1;
                state_next    = S_WPUT;
            end
            S_WPUT:
            begin
                cmd.tbl_put = 1'b1;
                cmd.sub_clr = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_HDR;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_WISS;
                end
            end
            S_HDR:
            begin
                cmd.load   = LD_HDR;
                state_next = S_OUT;
                if (!sts.hdr_last)
                begin
                    cmd.idx_inc = 1'b1;
                    ret_next    = S_HDR;
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    if (sts.kind == K_RCOIL && !sts.cnt_zero)
                        ret_next = S_GATH;
                    else if (sts.kind == K_RREG && !sts.cnt_zero)
                        ret_next = S_RRD;
                    else
                        ret_next = S_CLO;
                end
            end
            S_GATH:
            begin
                cmd.gather  = 1'b1;
                cmd.sub_inc = 1'b1;
                if (sts.sub_eight)
                    state_next = S_CBYTE;
            end
            S_CBYTE:
            begin
                cmd.load    = LD_COIL;
                cmd.sub_clr = 1'b1;
                cmd.idx_inc = 1'b1;
                ret_next    = sts.idx_last ? S_CLO : S_GATH;
                state_next  = S_OUT;
            end
            S_RRD:
            begin
                cmd.reg_issue = 1'b1;
                state_next    = S_RHI;
            end
            S_RHI:
            begin
                cmd.load   = LD_RHI;
                ret_next   = S_RLO;
                state_next = S_OUT;
            end
            S_RLO:
            begin
                cmd.load    = LD_RLO;
                cmd.idx_inc = 1'b1;
                ret_next    = sts.idx_last ? S_CLO : S_RRD;
                state_next  = S_OUT;
            end
            S_CLO:
            begin
                cmd.load   = LD_CLO;
                ret_next   = S_CHI;
                state_next = S_OUT;
            end
            S_CHI:
            begin
                // restart the CRC for the next received frame
                cmd.load      = LD_CHI;
                cmd.frame_clr = 1'b1;
                ret_next      = S_RECV;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = ret_reg;
            end
            default:
            begin
                state_next = S_RECV;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RECV;
            ret_reg   <= S_RECV;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("receive and transmit active together");

    a_check_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |=> (state_reg == S_RECV || state_reg == S_PUT
                                    || state_reg == S_WISS || state_reg == S_HDR))
        else $error("bad exit from frame check");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(ret_reg)))
        else $error("reply byte lost under stall");

    a_crc_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLO) |=> (state_reg == S_OUT && ret_reg == S_CHI))
        else $error("CRC bytes out of order");

endmodule

[rtl/modbus_rtu_slave_frame_engine.sv]
// Top level of the Modbus RTU slave frame engine.
// Channels: rx takes request bytes, frame_end set on the last byte of a frame;
// tx gives reply bytes, CRC low byte then high byte, tx_last on the final one.
// Configuration: cfg_we/cfg_index/cfg_wdata write device_id (0) and table_limit (1).
// A frame is dropped without a reply on a wrong unit id, bad CRC, unsupported
// function code, bad length or a reply longer than MAX_REPLY bytes.
// Sequencing: rx takes frame bytes in S_RECV. After the last byte, S_CHECK
// checks the frame; multiple writes pass S_WISS and S_WPUT per coil, adding
// S_WHI per register, set by the single frame-buffer read port. Each reply
// byte is loaded, then held in S_OUT until taken; a packed coil byte is first
// gathered one bit a cycle from the coil table in S_GATH, a register read in
// S_RRD. rx is not ready while a frame is checked, applied or answered.
// Reset clears the tables (per-entry valid bits), the frame count and the
// registers to device_id 50 and table_limit 100; no clearing pass is needed.
// When the receiver stalls, the reply byte holds on tx until transferred.
module modbus_rtu_slave_frame_engine
    import mrs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int MAX_REPLY   = MAX_REPLY_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    mrs_rx_if.sink               rx,
    mrs_tx_if.source             tx,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata
);

    logic [7:0] device_id_reg;
    logic [7:0] table_limit_reg;
    logic       rx_fire;
    mrs_cmd_t   cmd;
    mrs_sts_t   sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg   <= DEVICE_ID_RST;
            table_limit_reg <= TABLE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEVICE_ID:   device_id_reg   <= cfg_wdata;
                REG_TABLE_LIMIT: table_limit_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    assign rx_fire = rx.valid && rx.ready;

    mrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx.valid),
        .frame_end (rx.frame_end),
        .in_ready  (rx.ready),
        .out_valid (tx.valid),
        .out_ready (tx.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mrs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAME_BYTES (FRAME_BYTES),
        .MAX_REPLY   (MAX_REPLY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_fire     (rx_fire),
        .rx_byte     (rx.rx_byte),
        .device_id   (device_id_reg),
        .table_limit (table_limit_reg),
        .cmd         (cmd),
        .sts         (sts),
        .tx_byte     (tx.tx_byte),
        .tx_last     (tx.tx_last)
    );

endmodule

[bench/tb_channels.sv]
// Testbench channel interfaces are the RTL ones; this file holds the frame builder package.
`timescale 1ns / 100ps
package tb_frames_pkg;
    import mrs_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } rx_beat_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } tx_beat_t;

    function automatic logic [15:0] modbus_crc(input logic [7:0] b[$]);
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (b[i])
        begin
            c = c ^ {8'h00, b[i]};
            for (int k = 0; k < 8; k++)
            begin
                c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
            end
        end
        return c;
    endfunction
endpackage

[bench/testbench.sv]
// Self-checking bench for the Modbus RTU slave frame engine: random and directed frames.
`timescale 1ns / 100ps
module testbench;
    import mrs_pkg::*;
    import tb_frames_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0] cfg_wdata = '0;

    mrs_rx_if rx();
    mrs_tx_if tx();

    modbus_rtu_slave_frame_engine dut (
        .clk(clk), .rst_n(rst_n), .rx(rx.sink), .tx(tx.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #4 clk = ~clk;

    rx_beat_t pending_bytes[$];
    tx_beat_t expected_reply[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    bit in_fire = 0;
    int mismatches = 0;
    longint cycles = 0;

    logic [7:0] unit_id = DEVICE_ID_RST;
    logic [7:0] limit_reg = TABLE_LIMIT_RST;
    logic [7:0] frame_store[64];
    int stored = 0;
    bit overflowed = 0;
    bit coils[128];
    logic [15:0] regs[128];

    function automatic int active_limit();
        return limit_reg < 128 ? limit_reg : 128;
    endfunction

    function automatic logic [15:0] word_from(int p);
        return {frame_store[p], frame_store[p+1]};
    endfunction

    function automatic void emit_reply(input logic [7:0] body[$]);
        logic [15:0] c;
        tx_beat_t t;
        if (body.size() + 2 > 64)
            return;
        c = modbus_crc(body);
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        foreach (body[i])
        begin
            t.data = body[i];
            t.last = (i == body.size() - 1);
            expected_reply.push_back(t);
        end
    endfunction

    function automatic void answer_frame(int n);
        logic [7:0] fc, bc;
        logic [7:0] body[$];
        logic [7:0] pk;
        int addr, qty, lim, nb, a;
        fc = frame_store[1];
        lim = active_limit();
        if (fc >= 1 && fc <= 6 && n != 8)
            return;
        addr = word_from(2);
        qty = word_from(4);
        body = {frame_store[0], fc};
        case (fc)
            FC_RD_COILS, FC_RD_INPUTS:
            begin
                nb = (qty + 7) / 8;
                if (nb + 5 > 64)
                    return;
                body.push_back(nb[7:0]);
                for (int j = 0; j < nb; j++)
                begin
                    pk = 0;
                    for (int k = 0; k < 8; k++)
                    begin
                        a = addr + j * 8 + k;
                        if (j * 8 + k < qty && a < lim && coils[a])
                            pk[k] = 1;
                    end
                    body.push_back(pk);
                end
                emit_reply(body);
                return;
            end
            FC_RD_HOLD, FC_RD_INREG:
            begin
                if (2 * qty + 5 > 64)
                    return;
                body.push_back(8'(2 * qty));
                for (int j = 0; j < qty; j++)
                begin
                    a = addr + j;
                    body.push_back(a < lim ? regs[a][15:8] : 8'h00);
                    body.push_back(a < lim ? regs[a][7:0] : 8'h00);
                end
                emit_reply(body);
                return;
            end
            FC_WR_COIL: if (addr < lim) coils[addr] = (qty != 0);
            FC_WR_REG:  if (addr < lim) regs[addr] = qty[15:0];
            FC_WR_COILS:
            begin
                if (n < 9)
                    return;
                bc = frame_store[6];
                if (n != 9 + bc || (qty + 7) / 8 > bc)
                    return;
                for (int j = 0; j < qty; j++)
                    if (addr + j < lim)
                        coils[addr + j] = frame_store[7 + j / 8][j % 8];
            end
            FC_WR_REGS:
            begin
                if (n < 9)
                    return;
                bc = frame_store[6];
                if (n != 9 + bc || 2 * qty > bc)
                    return;
                for (int j = 0; j < qty; j++)
                    if (addr + j < lim)
                        regs[addr + j] = word_from(7 + 2 * j);
            end
            default: return;
        endcase
        body = {};
        for (int j = 0; j < 6; j++)
            body.push_back(frame_store[j]);
        emit_reply(body);
    endfunction

    function automatic void take_byte(rx_beat_t b);
        logic [7:0] head[$];
        logic [15:0] c;
        int n;
        if (stored < 64)
            frame_store[stored++] = b.data;
        else
            overflowed = 1;
        if (!b.fin)
            return;
        n = stored;
        stored = 0;
        if (overflowed || n < 4 || frame_store[0] != unit_id)
        begin
            overflowed = 0;
            return;
        end
        overflowed = 0;
        for (int j = 0; j < n - 2; j++)
            head.push_back(frame_store[j]);
        c = modbus_crc(head);
        if (frame_store[n-2] != c[7:0] || frame_store[n-1] != c[15:8])
            return;
        answer_frame(n);
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
            rx.valid <= 0;
        else if (!rx.valid || in_fire)
        begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                rx.valid <= 1;
                rx.rx_byte <= pending_bytes[0].data;
                rx.frame_end <= pending_bytes[0].fin;
            end
            else
                rx.valid <= 0;
        end
        tx.ready <= (hold_cycles == 0) && $urandom_range(99) >= recv_stall_pct;
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    always @(posedge clk)
    begin
        rx_beat_t b;
        tx_beat_t e;
        cycles <= cycles + 1;
        in_fire = rst_n && rx.valid && rx.ready;
        if (in_fire)
        begin
            b = pending_bytes.pop_front();
            take_byte(b);
        end
        if (rst_n && tx.valid && tx.ready)
        begin
            if (expected_reply.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: byte %h last %b", tx.tx_byte, tx.tx_last);
            end
            else
            begin
                e = expected_reply.pop_front();
                if (e.data !== tx.tx_byte || e.last !== tx.tx_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%b, got %h/%b",
                                 e.data, e.last, tx.tx_byte, tx.tx_last);
                end
            end
        end
        if (cycles > 3000000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic queue_frame(input logic [7:0] body[$], input bit good_crc);
        logic [15:0] c;
        rx_beat_t b;
        c = modbus_crc(body);
        if (!good_crc)
            c ^= 16'(1 << $urandom_range(15));
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        foreach (body[i])
        begin
            b.data = body[i];
            b.fin = (i == body.size() - 1);
            pending_bytes.push_back(b);
        end
    endtask

    task automatic queue_request(input logic [7:0] fc, input int addr, input int qty,
                                 input bit good_crc);
        logic [7:0] body[$];
        int nb;
        body = {unit_id, fc, 8'(addr >> 8), 8'(addr), 8'(qty >> 8), 8'(qty)};
        if (fc == FC_WR_COILS || fc == FC_WR_REGS)
        begin
            nb = (fc == FC_WR_COILS) ? (qty + 7) / 8 : 2 * qty;
            body.push_back(nb[7:0]);
            for (int j = 0; j < nb; j++)
                body.push_back(8'($urandom));
        end
        queue_frame(body, good_crc);
    endtask

    task automatic drain();
        while (pending_bytes.size() > 0 || expected_reply.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 0;
        if (idx == REG_DEVICE_ID)
            unit_id = v;
        else
            limit_reg = v;
    endtask

    task automatic random_frames(input int count);
        logic [7:0] codes[8] = '{FC_RD_COILS, FC_RD_INPUTS, FC_RD_HOLD, FC_RD_INREG,
                                 FC_WR_COIL, FC_WR_REG, FC_WR_COILS, FC_WR_REGS};
        logic [7:0] body[$];
        logic [7:0] fc;
        int kind, addr, qty, len;
        for (int f = 0; f < count; f++)
        begin
            kind = $urandom_range(99);
            fc = codes[$urandom_range(7)];
            addr = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(140);
            if (fc == FC_WR_COIL || fc == FC_WR_REG)
                qty = ($urandom_range(3) == 0) ? 0 : $urandom_range(65535);
            else if (fc == FC_WR_REGS)
                qty = $urandom_range(8);
            else if (fc == FC_WR_COILS)
                qty = $urandom_range(80);
            else if (fc == FC_RD_HOLD || fc == FC_RD_INREG)
                qty = $urandom_range(31);
            else
                qty = $urandom_range(470);
            if (kind < 80)
                queue_request(fc, addr, qty, 1);
            else if (kind < 87)
                queue_request(fc, addr, qty, 0);
            else
            begin
                body = {};
                len = $urandom_range(1, 24);
                body.push_back(($urandom_range(1)) ? unit_id : 8'($urandom));
                body.push_back(($urandom_range(1)) ? fc : 8'($urandom));
                for (int j = 2; j < len; j++)
                    body.push_back(8'($urandom));
                queue_frame(body, $urandom_range(1));
            end
            while (pending_bytes.size() > 200)
                @(posedge clk);
        end
    endtask

    initial
    begin
        logic [7:0] body[$];
        rx.valid = 0;
        rx.rx_byte = 0;
        rx.frame_end = 0;
        tx.ready = 0;
        foreach (coils[i])
        begin
            coils[i] = 0;
            regs[i] = 0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        queue_request(FC_WR_REG, 0, 16'hFFFF, 1);
        queue_request(FC_WR_REG, 99, 16'h8001, 1);
        queue_request(FC_WR_REG, 100, 16'h1234, 1);
        queue_request(FC_WR_COIL, 3, 16'hFF00, 1);
        queue_request(FC_WR_COIL, 3, 0, 1);
        queue_request(FC_WR_COIL, 7, 1, 1);
        queue_request(FC_WR_COILS, 90, 19, 1);
        queue_request(FC_WR_REGS, 95, 8, 1);
        queue_request(FC_WR_REGS, 10, 0, 1);
        queue_request(FC_RD_COILS, 0, 0, 1);
        queue_request(FC_RD_COILS, 85, 40, 1);
        queue_request(FC_RD_INPUTS, 65535, 16, 1);
        queue_request(FC_RD_COILS, 0, 472, 1);
        queue_request(FC_RD_HOLD, 94, 8, 1);
        queue_request(FC_RD_INREG, 0, 29, 1);
        queue_request(FC_RD_HOLD, 0, 30, 1);
        queue_request(FC_RD_HOLD, 0, 2, 0);
        queue_request(8'h07, 0, 2, 1);
        body = {unit_id, FC_RD_HOLD, 8'h00};
        queue_frame(body, 1);
        body = {unit_id, FC_RD_HOLD, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00};
        queue_frame(body, 1);
        body = {unit_id};
        queue_frame(body, 1);
        body = {unit_id, FC_WR_REGS, 8'h00, 8'h00, 8'h00, 8'h04, 8'h02, 8'h11, 8'h22};
        queue_frame(body, 1);
        body = {8'hFF, FC_RD_HOLD, 8'h00, 8'h00, 8'h00, 8'h01};
        queue_frame(body, 1);
        body = {};
        for (int j = 0; j < 70; j++)
            body.push_back(j == 0 ? unit_id : 8'($urandom));
        queue_frame(body, 1);
        drain();

        send_idle_pct = 0; recv_stall_pct = 0;
        random_frames(3);
        hold_cycles = 600;
        queue_request(FC_RD_HOLD, 0, 20, 1);
        queue_request(FC_RD_HOLD, 5, 20, 1);
        queue_request(FC_RD_COILS, 0, 64, 1);
        wait (hold_cycles == 0);
        drain();

        write_reg(REG_DEVICE_ID, 8'd0);
        write_reg(REG_TABLE_LIMIT, 8'd128);
        send_idle_pct = 83; recv_stall_pct = 0;
        random_frames(3);
        drain();

        write_reg(REG_DEVICE_ID, 8'd255);
        write_reg(REG_TABLE_LIMIT, 8'd0);
        send_idle_pct = 0; recv_stall_pct = 83;
        random_frames(3);
        drain();

        write_reg(REG_DEVICE_ID, 8'd1);
        write_reg(REG_TABLE_LIMIT, 8'd255);
        send_idle_pct = 26; recv_stall_pct = 26;
        random_frames(3);
        drain();

        write_reg(REG_DEVICE_ID, 8'd50);
        write_reg(REG_TABLE_LIMIT, 8'd37);
        send_idle_pct = 0; recv_stall_pct = 0;
        random_frames(3);
        drain();

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

[sim.f]
rtl/mrs_pkg.sv
rtl/mrs_rx_if.sv
rtl/mrs_tx_if.sv
rtl/mrs_datapath.sv
rtl/mrs_ctrl.sv
rtl/modbus_rtu_slave_frame_engine.sv
bench/tb_channels.sv
bench/testbench.sv
